// ----- rtl/disc_tray_loader_controller_unit_defines.svh -----
// Assertion macros shared by the disc tray loader controller RTL.
`ifndef DISC_TRAY_LOADER_CONTROLLER_UNIT_DEFINES_SVH
`define DISC_TRAY_LOADER_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DTL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtl same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtl next-cycle check failed");

`endif

// ----- rtl/dtl_pkg.sv -----
// Package: types, codes and reset defaults of the disc tray loader controller.
`timescale 1ns / 1ps

package dtl_pkg;

    // command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_POWER = 2'd1;
    localparam logic [1:0] CMD_DISC  = 2'd2;
    localparam logic [1:0] CMD_FORCE = 2'd3;

    // command arguments
    localparam logic [1:0] ARG_OFF_LOAD = 2'd0;
    localparam logic [1:0] ARG_ON_EJECT = 2'd1;

    // configuration register indexes
    localparam logic [2:0] REG_SETTLE      = 3'd0;
    localparam logic [2:0] REG_RESET_HOLD  = 3'd1;
    localparam logic [2:0] REG_RESET_REL   = 3'd2;
    localparam logic [2:0] REG_OFF_DELAY   = 3'd3;
    localparam logic [2:0] REG_AUDIO_READY = 3'd4;
    localparam logic [2:0] REG_AUTO_INJECT = 3'd5;
    localparam logic [2:0] REG_FORCE_EJECT = 3'd6;

    // reset defaults
    localparam logic [7:0]  DEF_SETTLE      = 8'd4;
    localparam logic [7:0]  DEF_RESET_HOLD  = 8'd16;
    localparam logic [7:0]  DEF_RESET_REL   = 8'd50;
    localparam logic [7:0]  DEF_OFF_DELAY   = 8'd83;
    localparam logic [7:0]  DEF_AUDIO_READY = 8'd125;
    localparam logic [15:0] DEF_AUTO_INJECT = 16'd833;
    localparam logic [15:0] DEF_FORCE_EJECT = 16'd500;

    // power timer ceiling
    localparam logic [8:0] POWER_TICK_CAP = 9'd250;

    typedef struct packed {
        logic       machine_power;
        logic       tray_out_level;
        logic       tray_in_level;
        logic       disc_detect_level;
        logic [1:0] cmd;
        logic [1:0] cmd_arg;
    } t_item;

    typedef struct packed {
        logic [7:0]  settle_ticks;
        logic [7:0]  reset_hold_ticks;
        logic [7:0]  reset_release_ticks;
        logic [7:0]  power_off_delay_ticks;
        logic [7:0]  audio_ready_ticks;
        logic [15:0] auto_inject_ticks;
        logic [15:0] force_eject_ticks;
    } t_cfg;

    typedef struct packed {
        logic       supply_enable;
        logic       reset_release;
        logic       load_forward;
        logic       load_reverse;
        logic [2:0] disc_status;
        logic       disc_changed;
        logic       power_notify;
        logic       audio_ready;
    } t_result;

    // core status seen by the top level checks
    typedef struct packed {
        logic [3:0]  pin_levels;
        logic [15:0] force_count;
        logic        powered_up;
        logic [7:0]  power_ticks;
    } t_state;

endpackage

// ----- rtl/dtl_outq.sv -----
// Two-entry result queue between the core and the master stream.
`timescale 1ns / 1ps

module dtl_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dtl_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output dtl_pkg::t_result o_data,
    input  logic             i_pop_ready
);

    dtl_pkg::t_result r_buf [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf[r_rd_ptr];
    assign w_pop   = o_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/dtl_core.sv -----
// Per-tick state update: power sequencing, forced eject and disc phase machine.
`timescale 1ns / 1ps

module dtl_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  dtl_pkg::t_item   i_item,
    input  dtl_pkg::t_cfg    i_cfg,
    output dtl_pkg::t_result o_result,
    output dtl_pkg::t_state  o_state
);

    typedef enum logic [2:0] {
        PH_UNKNOWN = 3'd0,
        PH_NODISC  = 3'd1,
        PH_READY   = 3'd2,
        PH_OUTSIDE = 3'd3,
        PH_INJECT  = 3'd4,
        PH_EJECT   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_EJECT = 2'd2
    } t_req;

    localparam logic [1:0] PIN_SUPPLY = 2'd0;
    localparam logic [1:0] PIN_RESET  = 2'd1;
    localparam logic [1:0] PIN_FWD    = 2'd2;
    localparam logic [1:0] PIN_REV    = 2'd3;

    t_phase      r_phase,   n_phase;
    t_req        r_req,     n_req;
    logic        r_pu,      n_pu;
    logic [7:0]  r_pt,      n_pt;
    logic [7:0]  r_settle,  n_settle;
    logic [15:0] r_outside, n_outside;
    logic [15:0] r_force,   n_force;
    logic [3:0]  r_pins,    n_pins;

    t_phase      w_cur;
    logic        w_changed;
    logic        w_notify;
    logic [8:0]  w_pt_inc;
    logic [8:0]  w_settle_inc;
    logic [16:0] w_outside_inc;

    // sensed phase from the pins; the ambiguous combination uses the history
    function automatic t_phase sense(input logic tout, input logic tin, input logic det,
                                     input t_phase phase, input t_req req);
        t_phase res;
        res = PH_UNKNOWN;
        if (!tin) begin
            res = PH_NODISC;
        end else if (tout && !det) begin
            res = PH_READY;
        end else if (!tout && det) begin
            res = PH_OUTSIDE;
        end else if (!tout && !det) begin
            res = PH_UNKNOWN;
        end else begin
            case (phase)
                PH_NODISC, PH_OUTSIDE: res = PH_INJECT;
                PH_READY:              res = PH_EJECT;
                PH_EJECT:              res = (req == REQ_LOAD)  ? PH_INJECT : PH_EJECT;
                PH_INJECT:             res = (req == REQ_EJECT) ? PH_EJECT  : PH_INJECT;
                default:               res = PH_UNKNOWN;
            endcase
        end
        return res;
    endfunction

    always_comb begin
        n_phase       = r_phase;
        n_req         = r_req;
        n_pu          = r_pu;
        n_pt          = r_pt;
        n_settle      = r_settle;
        n_outside     = r_outside;
        n_force       = r_force;
        n_pins        = r_pins;
        w_changed     = 1'b0;
        w_notify      = 1'b0;
        w_pt_inc      = 9'd0;
        w_settle_inc  = 9'd0;
        w_outside_inc = 17'd0;
        w_cur         = PH_UNKNOWN;

        if (i_item.machine_power) begin
            if (r_force != 16'd0) begin
                // forced eject: motor outward, then drop everything
                n_force         = r_force - 16'd1;
                n_pins[PIN_FWD] = 1'b0;
                if (n_force > {8'd0, i_cfg.reset_hold_ticks}) begin
                    n_pins[PIN_REV] = 1'b1;
                end else begin
                    n_pins    = 4'd0;
                    n_pu      = 1'b0;
                    n_phase   = PH_UNKNOWN;
                    n_req     = REQ_NONE;
                    n_outside = 16'd0;
                    n_pt      = 8'd0;
                    n_settle  = 8'd0;
                end
            end else begin
                case (i_item.cmd)
                    dtl_pkg::CMD_POWER: begin
                        if (i_item.cmd_arg == dtl_pkg::ARG_OFF_LOAD) begin
                            if (r_pu) begin
                                n_pu = 1'b0;
                                n_pt = 8'd0;
                            end
                            w_notify = 1'b1;
                        end else if (i_item.cmd_arg == dtl_pkg::ARG_ON_EJECT) begin
                            if (!r_pu) begin
                                n_pu = 1'b1;
                                n_pt = 8'd0;
                            end
                            w_notify = 1'b1;
                        end
                    end
                    dtl_pkg::CMD_DISC: begin
                        if (i_item.cmd_arg == dtl_pkg::ARG_OFF_LOAD) begin
                            n_req = REQ_LOAD;
                        end else if (i_item.cmd_arg == dtl_pkg::ARG_ON_EJECT &&
                                     r_phase != PH_UNKNOWN && r_phase != PH_NODISC) begin
                            n_req = REQ_EJECT;
                        end
                    end
                    dtl_pkg::CMD_FORCE: n_force = i_cfg.force_eject_ticks;
                    default: ;
                endcase

                // power sequencing
                w_pt_inc = {1'b0, n_pt} + 9'd1;
                if (n_pu) begin
                    n_pins[PIN_SUPPLY] = 1'b1;
                    if (w_pt_inc > {1'b0, i_cfg.reset_release_ticks}) begin
                        n_pins[PIN_RESET] = 1'b1;
                    end else if (w_pt_inc > {1'b0, i_cfg.reset_hold_ticks}) begin
                        n_pins[PIN_RESET] = 1'b0;
                    end
                end else if (w_pt_inc > {1'b0, i_cfg.power_off_delay_ticks}) begin
                    n_pins[PIN_SUPPLY] = 1'b0;
                    n_pins[PIN_RESET]  = 1'b0;
                end
                n_pt = (w_pt_inc > dtl_pkg::POWER_TICK_CAP) ? 8'(w_pt_inc - 9'd1)
                                                             : w_pt_inc[7:0];

                // disc phase machine
                w_cur = sense(i_item.tray_out_level, i_item.tray_in_level,
                              i_item.disc_detect_level, r_phase, n_req);
                if (r_phase == PH_UNKNOWN) begin
                    w_settle_inc = {1'b0, r_settle} + 9'd1;
                    if (w_settle_inc > {1'b0, i_cfg.settle_ticks}) begin
                        n_phase = w_cur;
                    end else begin
                        n_settle = w_settle_inc[7:0];
                    end
                end else begin
                    case (r_phase)
                        PH_READY: begin
                            if (n_req == REQ_EJECT) n_pins[PIN_REV] = 1'b1;
                        end
                        PH_OUTSIDE: begin
                            w_outside_inc = {1'b0, r_outside} + 17'd1;
                            if (w_outside_inc > {1'b0, i_cfg.auto_inject_ticks} ||
                                n_req == REQ_LOAD) begin
                                n_pins[PIN_FWD] = 1'b1;
                                n_outside       = 16'd0;
                            end else begin
                                n_outside = w_outside_inc[15:0];
                                if (w_cur == PH_NODISC) begin
                                    n_pins[PIN_FWD] = 1'b0;
                                    n_req           = REQ_NONE;
                                end
                            end
                        end
                        PH_INJECT: begin
                            if (w_cur == PH_READY || w_cur == PH_NODISC) begin
                                n_pins[PIN_FWD] = 1'b0;
                                n_req           = REQ_NONE;
                            end
                            if (n_req == REQ_EJECT) begin
                                n_pins[PIN_FWD] = 1'b0;
                                n_pins[PIN_REV] = 1'b1;
                            end
                        end
                        PH_EJECT: begin
                            if (w_cur == PH_OUTSIDE || w_cur == PH_NODISC) begin
                                n_pins[PIN_REV] = 1'b0;
                                n_req           = REQ_NONE;
                                n_outside       = 16'd0;
                            end
                            if (n_req == REQ_LOAD) begin
                                n_pins[PIN_REV] = 1'b0;
                                n_pins[PIN_FWD] = 1'b1;
                            end
                        end
                        PH_NODISC: begin
                            if (w_cur == PH_OUTSIDE) n_pins[PIN_FWD] = 1'b1;
                        end
                        default: ;
                    endcase
                    w_changed = (r_phase != w_cur);
                    n_phase   = w_cur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_UNKNOWN;
            r_req     <= REQ_NONE;
            r_pu      <= 1'b0;
            r_pt      <= 8'd0;
            r_settle  <= 8'd0;
            r_outside <= 16'd0;
            r_force   <= 16'd0;
            r_pins    <= 4'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_req     <= n_req;
            r_pu      <= n_pu;
            r_pt      <= n_pt;
            r_settle  <= n_settle;
            r_outside <= n_outside;
            r_force   <= n_force;
            r_pins    <= n_pins;
        end
    end

    always_comb begin
        o_result.supply_enable = n_pins[PIN_SUPPLY];
        o_result.reset_release = n_pins[PIN_RESET];
        o_result.load_forward  = n_pins[PIN_FWD];
        o_result.load_reverse  = n_pins[PIN_REV];
        o_result.disc_status   = n_phase;
        o_result.disc_changed  = w_changed;
        o_result.power_notify  = w_notify;
        o_result.audio_ready   = n_pu && (n_pt >= i_cfg.audio_ready_ticks);
    end

    assign o_state.pin_levels  = r_pins;
    assign o_state.force_count = r_force;
    assign o_state.powered_up  = r_pu;
    assign o_state.power_ticks = r_pt;

endmodule

// ----- rtl/disc_tray_loader_controller_unit.sv -----
// Top level of the disc tray loader controller: config registers, core and result queue.
`timescale 1ns / 1ps
`include "disc_tray_loader_controller_unit_defines.svh"

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: tick sensors + cmd_arg, tuser: cmd
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: drive lines and disc status
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One tick request is taken per cycle while the queue has room; its result goes to the queue.
// The core's per-tick update is a single combinational pass from the state registers
// into the two-entry result queue, so throughput is one request per clock.
// s_axis stalls only when both queue entries hold results not yet taken.
// Reset (synchronous, active low) clears state and queue and loads register defaults.
// Config writes are always accepted; write them only while the block is idle.

module disc_tray_loader_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] machine_power [1] tray_out_level [2] tray_in_level [3] disc_detect_level
    // [5:4] cmd_arg [7:6] zero
    input  logic [7:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] supply_enable [1] reset_release [2] load_forward [3] load_reverse
    // [6:4] disc_status [7] disc_changed [8] power_notify [9] audio_ready [15:10] zero
    output logic [15:0] m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    dtl_pkg::t_cfg    r_cfg;
    dtl_pkg::t_item   w_item;
    dtl_pkg::t_result w_core_result;
    dtl_pkg::t_result w_out;
    dtl_pkg::t_state  w_state;
    logic             w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // unpack the tick request
    assign w_item.machine_power     = s_axis_tdata[0];
    assign w_item.tray_out_level    = s_axis_tdata[1];
    assign w_item.tray_in_level     = s_axis_tdata[2];
    assign w_item.disc_detect_level = s_axis_tdata[3];
    assign w_item.cmd_arg           = s_axis_tdata[5:4];
    assign w_item.cmd               = s_axis_tuser;

    // configuration registers; narrow ones take the low byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks          <= dtl_pkg::DEF_SETTLE;
            r_cfg.reset_hold_ticks      <= dtl_pkg::DEF_RESET_HOLD;
            r_cfg.reset_release_ticks   <= dtl_pkg::DEF_RESET_REL;
            r_cfg.power_off_delay_ticks <= dtl_pkg::DEF_OFF_DELAY;
            r_cfg.audio_ready_ticks     <= dtl_pkg::DEF_AUDIO_READY;
            r_cfg.auto_inject_ticks     <= dtl_pkg::DEF_AUTO_INJECT;
            r_cfg.force_eject_ticks     <= dtl_pkg::DEF_FORCE_EJECT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dtl_pkg::REG_SETTLE:      r_cfg.settle_ticks          <= i_cfg_data[7:0];
                dtl_pkg::REG_RESET_HOLD:  r_cfg.reset_hold_ticks      <= i_cfg_data[7:0];
                dtl_pkg::REG_RESET_REL:   r_cfg.reset_release_ticks   <= i_cfg_data[7:0];
                dtl_pkg::REG_OFF_DELAY:   r_cfg.power_off_delay_ticks <= i_cfg_data[7:0];
                dtl_pkg::REG_AUDIO_READY: r_cfg.audio_ready_ticks     <= i_cfg_data[7:0];
                dtl_pkg::REG_AUTO_INJECT: r_cfg.auto_inject_ticks     <= i_cfg_data;
                dtl_pkg::REG_FORCE_EJECT: r_cfg.force_eject_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-tick update; state advances on each accepted request
    dtl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_core_result),
        .o_state  (w_state)
    );

    // result queue decouples the two stream sides
    dtl_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_core_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (w_out),
        .i_pop_ready (m_axis_tready)
    );

    // pack the result
    assign m_axis_tdata = {6'd0,
                           w_out.audio_ready,
                           w_out.power_notify,
                           w_out.disc_changed,
                           w_out.disc_status,
                           w_out.load_reverse,
                           w_out.load_forward,
                           w_out.reset_release,
                           w_out.supply_enable};

    // a stalled input side means the queue is full, so a result must be on offer
    `DTL_ASSERT_IMPLIES(a_stall_has_result, !s_axis_tready, m_axis_tvalid)
    // a tick without machine power leaves the drive state untouched
    `DTL_ASSERT_NEXT(a_no_power_freezes, w_accept && !w_item.machine_power, $stable(w_state))
    // a running forced eject never drives the inject motor
    `DTL_ASSERT_NEXT(a_force_no_forward,
        w_accept && w_item.machine_power && (w_state.force_count != 16'd0),
        !w_state.pin_levels[2])

endmodule

// ----- bench/tb.sv -----
// Testbench for the disc tray loader controller: directed tick table, then random ticks vs a model.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_TICKS = 170;
    // forced eject length used after the ceiling phase; the hold tail stays at 255
    localparam logic [15:0] CEIL_FORCE_LEN = 16'd300;

    typedef dtl_pkg::t_item   t_item;
    typedef dtl_pkg::t_result t_result;
    typedef dtl_pkg::t_cfg    t_cfg;

    localparam logic [1:0] CMD_NONE     = dtl_pkg::CMD_NONE;
    localparam logic [1:0] CMD_POWER    = dtl_pkg::CMD_POWER;
    localparam logic [1:0] CMD_DISC     = dtl_pkg::CMD_DISC;
    localparam logic [1:0] CMD_FORCE    = dtl_pkg::CMD_FORCE;
    localparam logic [1:0] ARG_OFF_LOAD = dtl_pkg::ARG_OFF_LOAD;
    localparam logic [1:0] ARG_ON_EJECT = dtl_pkg::ARG_ON_EJECT;

    // cmd_arg values with no meaning for any command
    localparam logic [1:0] ARG_SPARE_2 = 2'd2;
    localparam logic [1:0] ARG_SPARE_3 = 2'd3;

    typedef enum logic [2:0] {
        ST_UNKNOWN, ST_EMPTY, ST_READY, ST_OUTSIDE, ST_LOADING, ST_EJECTING
    } t_tray_st;

    typedef enum logic [1:0] {RQ_NONE, RQ_LOAD, RQ_EJECT} t_req;

    typedef enum {PAT_EMPTY, PAT_READY, PAT_OUTSIDE, PAT_MOVING, PAT_AMBIG, PAT_NOISE} t_pin_pat;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_result res;
    } t_dir_row;

    localparam t_result RES_FROZEN   = '0;
    localparam t_result RES_UNUSED   = '0;
    // supply on, power notify, still settling
    localparam t_result RES_POWER_UP = '{1'b1, 1'b0, 1'b0, 1'b0, ST_UNKNOWN, 1'b0, 1'b1, 1'b0};
    localparam t_item   FORCE_TICK   = '{1'b1, 1'b1, 1'b1, 1'b1, CMD_FORCE, ARG_OFF_LOAD};

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // model of the block
    t_cfg        cfg;
    t_tray_st    tray_st;
    t_req        pend_req;
    logic        up;
    logic [8:0]  pwr_ticks;
    logic [7:0]  settle_cnt;
    logic [15:0] out_cnt;
    logic [15:0] force_cnt;
    logic        supply, rst_rel, fwd, rev;

    t_result     expected_drive_q[$];
    int          err_cnt = 0;
    int unsigned src_idle_pct = 0;
    int unsigned dst_idle_pct = 0;
    int unsigned force_pct = 0;
    t_pin_pat    pin_pat = PAT_EMPTY;
    int          pat_left = 0;

    // mp, tray_out, tray_in, detect, cmd, arg | typed | result
    t_dir_row dir_tab [21] = '{
        '{'{1'b0, 1'b1, 1'b1, 1'b1, CMD_POWER, ARG_ON_EJECT}, 1'b1, RES_FROZEN},
        '{'{1'b1, 1'b0, 1'b0, 1'b0, CMD_POWER, ARG_ON_EJECT}, 1'b1, RES_POWER_UP},
        '{'{1'b1, 1'b0, 1'b0, 1'b0, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b0, 1'b1, CMD_DISC,  ARG_ON_EJECT}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b0, 1'b0, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b0, 1'b0, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b1, 1'b1, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b0, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b0, CMD_DISC,  ARG_ON_EJECT}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, CMD_DISC,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b0, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b0, CMD_DISC,  ARG_SPARE_3},  1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b0, CMD_POWER, ARG_SPARE_2},  1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b1, 1'b0, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b1, 1'b1, CMD_NONE,  ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, CMD_FORCE, ARG_SPARE_3},  1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b1, 1'b1, CMD_POWER, ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b0, 1'b1, 1'b1, CMD_FORCE, ARG_OFF_LOAD}, 1'b0, RES_UNUSED},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, CMD_POWER, ARG_ON_EJECT}, 1'b0, RES_UNUSED}
    };

    disc_tray_loader_controller_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_drive_model();
        supply     = 1'b0;
        rst_rel    = 1'b0;
        fwd        = 1'b0;
        rev        = 1'b0;
        up         = 1'b0;
        tray_st    = ST_UNKNOWN;
        pend_req   = RQ_NONE;
        out_cnt    = '0;
        pwr_ticks  = '0;
        settle_cnt = '0;
    endfunction

    function automatic t_tray_st sense_tray(logic tout, logic tin, logic det);
        if (!tin) return ST_EMPTY;
        if (tout && !det) return ST_READY;
        if (!tout && det) return ST_OUTSIDE;
        if (!tout && !det) return ST_UNKNOWN;
        // both tray sensors and detect high: the tray is moving
        case (tray_st)
            ST_EMPTY, ST_OUTSIDE: return ST_LOADING;
            ST_READY:             return ST_EJECTING;
            ST_EJECTING:          return (pend_req == RQ_LOAD) ? ST_LOADING : ST_EJECTING;
            ST_LOADING:           return (pend_req == RQ_EJECT) ? ST_EJECTING : ST_LOADING;
            default:              return ST_UNKNOWN;
        endcase
    endfunction

    // one tick of the controller; returns the drive lines and status it reports
    function automatic t_result step_loader(t_item it);
        t_result    r;
        t_tray_st   seen;
        logic       chg;
        logic       ntf;
        logic [8:0] settle_next;
        logic [16:0] out_next;
        chg = 1'b0;
        ntf = 1'b0;
        if (it.machine_power) begin
            if (force_cnt != '0) begin
                force_cnt = force_cnt - 16'd1;
                fwd = 1'b0;
                if (force_cnt > {8'd0, cfg.reset_hold_ticks}) begin
                    rev = 1'b1;
                end else begin
                    clear_drive_model();
                end
            end else begin
                case (it.cmd)
                    CMD_POWER: begin
                        if (it.cmd_arg == ARG_OFF_LOAD) begin
                            if (up) begin
                                up = 1'b0;
                                pwr_ticks = '0;
                            end
                            ntf = 1'b1;
                        end else if (it.cmd_arg == ARG_ON_EJECT) begin
                            if (!up) begin
                                up = 1'b1;
                                pwr_ticks = '0;
                            end
                            ntf = 1'b1;
                        end
                    end
                    CMD_DISC: begin
                        if (it.cmd_arg == ARG_OFF_LOAD) begin
                            pend_req = RQ_LOAD;
                        end else if (it.cmd_arg == ARG_ON_EJECT && tray_st != ST_UNKNOWN
                                     && tray_st != ST_EMPTY) begin
                            pend_req = RQ_EJECT;
                        end
                    end
                    CMD_FORCE: force_cnt = cfg.force_eject_ticks;
                    default: ;
                endcase

                // power and reset sequencing
                pwr_ticks = pwr_ticks + 9'd1;
                if (up) begin
                    supply = 1'b1;
                    if (pwr_ticks > {1'b0, cfg.reset_release_ticks}) rst_rel = 1'b1;
                    else if (pwr_ticks > {1'b0, cfg.reset_hold_ticks}) rst_rel = 1'b0;
                end else if (pwr_ticks > {1'b0, cfg.power_off_delay_ticks}) begin
                    supply  = 1'b0;
                    rst_rel = 1'b0;
                end
                if (pwr_ticks > dtl_pkg::POWER_TICK_CAP) pwr_ticks = pwr_ticks - 9'd1;

                seen = sense_tray(it.tray_out_level, it.tray_in_level, it.disc_detect_level);
                if (tray_st == ST_UNKNOWN) begin
                    settle_next = {1'b0, settle_cnt} + 9'd1;
                    if (settle_next > {1'b0, cfg.settle_ticks}) tray_st = seen;
                    else settle_cnt = settle_next[7:0];
                end else begin
                    case (tray_st)
                        ST_READY: if (pend_req == RQ_EJECT) rev = 1'b1;
                        ST_OUTSIDE: begin
                            out_next = {1'b0, out_cnt} + 17'd1;
                            if (out_next > {1'b0, cfg.auto_inject_ticks}
                                || pend_req == RQ_LOAD) begin
                                fwd     = 1'b1;
                                out_cnt = '0;
                            end else begin
                                out_cnt = out_next[15:0];
                                if (seen == ST_EMPTY) begin
                                    fwd      = 1'b0;
                                    pend_req = RQ_NONE;
                                end
                            end
                        end
                        ST_LOADING: begin
                            if (seen == ST_READY || seen == ST_EMPTY) begin
                                fwd      = 1'b0;
                                pend_req = RQ_NONE;
                            end
                            if (pend_req == RQ_EJECT) begin
                                fwd = 1'b0;
                                rev = 1'b1;
                            end
                        end
                        ST_EJECTING: begin
                            if (seen == ST_OUTSIDE || seen == ST_EMPTY) begin
                                rev      = 1'b0;
                                pend_req = RQ_NONE;
                                out_cnt  = '0;
                            end
                            if (pend_req == RQ_LOAD) begin
                                rev = 1'b0;
                                fwd = 1'b1;
                            end
                        end
                        ST_EMPTY: if (seen == ST_OUTSIDE) fwd = 1'b1;
                        default: ;
                    endcase
                    chg     = (tray_st != seen);
                    tray_st = seen;
                end
            end
        end
        r.supply_enable = supply;
        r.reset_release = rst_rel;
        r.load_forward  = fwd;
        r.load_reverse  = rev;
        r.disc_status   = tray_st;
        r.disc_changed  = chg;
        r.power_notify  = ntf;
        r.audio_ready   = up && (pwr_ticks >= {1'b0, cfg.audio_ready_ticks});
        return r;
    endfunction

    function automatic t_result decode_result(logic [15:0] d);
        t_result r;
        r.supply_enable = d[0];
        r.reset_release = d[1];
        r.load_forward  = d[2];
        r.load_reverse  = d[3];
        r.disc_status   = d[6:4];
        r.disc_changed  = d[7];
        r.power_notify  = d[8];
        r.audio_ready   = d[9];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // random tick: tray pins follow held patterns so that the state machine moves
    function automatic t_item next_tick();
        t_item       it;
        int unsigned pick;
        int unsigned sub;
        if (pat_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 15)      pin_pat = PAT_EMPTY;
            else if (pick < 38) pin_pat = PAT_READY;
            else if (pick < 63) pin_pat = PAT_OUTSIDE;
            else if (pick < 88) pin_pat = PAT_MOVING;
            else if (pick < 94) pin_pat = PAT_AMBIG;
            else                pin_pat = PAT_NOISE;
            pat_left = (pin_pat == PAT_OUTSIDE) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        end
        pat_left--;
        it.machine_power = ($urandom_range(99) < 94);
        case (pin_pat)
            PAT_EMPTY: begin
                it.tray_out_level    = 1'($urandom_range(1));
                it.tray_in_level     = 1'b0;
                it.disc_detect_level = 1'($urandom_range(1));
            end
            PAT_READY:   {it.tray_out_level, it.tray_in_level, it.disc_detect_level} = 3'b110;
            PAT_OUTSIDE: {it.tray_out_level, it.tray_in_level, it.disc_detect_level} = 3'b011;
            PAT_MOVING:  {it.tray_out_level, it.tray_in_level, it.disc_detect_level} = 3'b111;
            PAT_AMBIG:   {it.tray_out_level, it.tray_in_level, it.disc_detect_level} = 3'b010;
            default: begin
                {it.tray_out_level, it.tray_in_level, it.disc_detect_level} = 3'($urandom_range(7));
            end
        endcase
        pick = $urandom_range(99);
        sub  = $urandom_range(9);
        if (pick < force_pct) begin
            it.cmd     = CMD_FORCE;
            it.cmd_arg = 2'($urandom_range(3));
        end else if (pick < force_pct + 6) begin
            it.cmd     = CMD_POWER;
            it.cmd_arg = (sub < 6) ? ARG_ON_EJECT : (sub < 9) ? ARG_OFF_LOAD :
                         ($urandom_range(1) ? ARG_SPARE_2 : ARG_SPARE_3);
        end else if (pick < force_pct + 20) begin
            it.cmd     = CMD_DISC;
            it.cmd_arg = (sub < 5) ? ARG_OFF_LOAD : (sub < 9) ? ARG_ON_EJECT :
                         ($urandom_range(1) ? ARG_SPARE_2 : ARG_SPARE_3);
        end else begin
            it.cmd     = CMD_NONE;
            it.cmd_arg = 2'($urandom_range(3));
        end
        return it;
    endfunction

    // offer one tick request; returns at the edge where it is taken
    task automatic send_tick(t_item it, logic typed, t_result typed_res);
        t_result exp_res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.cmd_arg, it.disc_detect_level, it.tray_in_level,
                          it.tray_out_level, it.machine_power};
        s_axis_tuser  <= it.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_res = step_loader(it);
        expected_drive_q.push_back(typed ? typed_res : exp_res);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            dtl_pkg::REG_SETTLE:      cfg.settle_ticks          = val[7:0];
            dtl_pkg::REG_RESET_HOLD:  cfg.reset_hold_ticks      = val[7:0];
            dtl_pkg::REG_RESET_REL:   cfg.reset_release_ticks   = val[7:0];
            dtl_pkg::REG_OFF_DELAY:   cfg.power_off_delay_ticks = val[7:0];
            dtl_pkg::REG_AUDIO_READY: cfg.audio_ready_ticks     = val[7:0];
            dtl_pkg::REG_AUTO_INJECT: cfg.auto_inject_ticks     = val;
            dtl_pkg::REG_FORCE_EJECT: cfg.force_eject_ticks     = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [7:0] settle, logic [7:0] hold, logic [7:0] rel,
                                 logic [7:0] off_dly, logic [7:0] audio,
                                 logic [15:0] auto_inj, logic [15:0] force_len);
        write_reg(dtl_pkg::REG_SETTLE,      {8'd0, settle});
        write_reg(dtl_pkg::REG_RESET_HOLD,  {8'd0, hold});
        write_reg(dtl_pkg::REG_RESET_REL,   {8'd0, rel});
        write_reg(dtl_pkg::REG_OFF_DELAY,   {8'd0, off_dly});
        write_reg(dtl_pkg::REG_AUDIO_READY, {8'd0, audio});
        write_reg(dtl_pkg::REG_AUTO_INJECT, auto_inj);
        write_reg(dtl_pkg::REG_FORCE_EJECT, force_len);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, let every result come back, then a short quiet gap
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_ticks(int n, int unsigned src_pct, int unsigned dst_pct,
                             int unsigned frc_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        force_pct    = frc_pct;
        repeat (n) send_tick(next_tick(), 1'b0, RES_UNUSED);
    endtask

    // keep ticking until a running forced eject has fully unwound
    task automatic finish_forced_eject();
        while (force_cnt != '0) send_tick(next_tick(), 1'b0, RES_UNUSED);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_result got_res;
        t_result exp_res;
        int      quiet_cycles;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_drive_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", m_axis_tdata);
                err_cnt++;
            end else begin
                exp_res = expected_drive_q.pop_front();
                got_res = decode_result(m_axis_tdata);
                check_field("supply_enable", exp_res.supply_enable, got_res.supply_enable);
                check_field("reset_release", exp_res.reset_release, got_res.reset_release);
                check_field("load_forward",  exp_res.load_forward,  got_res.load_forward);
                check_field("load_reverse",  exp_res.load_reverse,  got_res.load_reverse);
                check_field("disc_status",   exp_res.disc_status,   got_res.disc_status);
                check_field("disc_changed",  exp_res.disc_changed,  got_res.disc_changed);
                check_field("power_notify",  exp_res.power_notify,  got_res.power_notify);
                check_field("audio_ready",   exp_res.audio_ready,   got_res.audio_ready);
            end
        end
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[disc_tray_loader_controller_unit] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_NONE;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = dtl_pkg::REG_SETTLE;
        i_cfg_data    = '0;
        cfg = '{dtl_pkg::DEF_SETTLE, dtl_pkg::DEF_RESET_HOLD, dtl_pkg::DEF_RESET_REL,
                dtl_pkg::DEF_OFF_DELAY, dtl_pkg::DEF_AUDIO_READY,
                dtl_pkg::DEF_AUTO_INJECT, dtl_pkg::DEF_FORCE_EJECT};
        force_cnt = '0;
        clear_drive_model();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk at reset defaults: settle, load, eject, reversal, ambiguous pins,
        // frozen ticks, unused arguments, power off and a forced eject
        src_idle_pct = 26;
        dst_idle_pct = 57;
        foreach (dir_tab[i]) send_tick(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
        finish_forced_eject();
        drain_results();

        // short random timings
        load_settings(8'($urandom_range(6)), 8'($urandom_range(20)), 8'($urandom_range(40)),
                      8'($urandom_range(30)), 8'($urandom_range(60)),
                      16'($urandom_range(30)), 16'($urandom_range(40)));
        run_ticks(PHASE_TICKS, 26, 57, 3);
        drain_results();

        // every timing at zero
        load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
        run_ticks(PHASE_TICKS, 57, 26, 3);
        drain_results();

        // every timing at its ceiling, then a forced eject with the hold tail at its ceiling
        load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        run_ticks(PHASE_TICKS, 0, 0, 0);
        drain_results();
        write_reg(dtl_pkg::REG_FORCE_EJECT, CEIL_FORCE_LEN);
        i_cfg_valid <= 1'b0;
        send_tick(FORCE_TICK, 1'b0, RES_UNUSED);
        finish_forced_eject();
        drain_results();

        // mixed timings; hold, release, power-off delay and audio ready over the full 8-bit range
        load_settings(8'($urandom_range(10)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      16'($urandom_range(60)), 16'($urandom_range(300)));
        run_ticks(PHASE_TICKS, 0, 0, 3);
        drain_results();

        if (err_cnt == 0) begin
            $display("[disc_tray_loader_controller_unit] OK");
        end else begin
            $display("[disc_tray_loader_controller_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dtl_pkg.sv
rtl/dtl_outq.sv
rtl/dtl_core.sv
rtl/disc_tray_loader_controller_unit.sv
bench/tb.sv
